// ===== src/utf8r_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8r_pkg
// Shared types and helpers for the UTF-8 character reassembler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package utf8r_pkg;

  localparam int unsigned HeldDepth = 3;
  localparam int unsigned MaxRes    = 3;

  localparam logic [7:0] LeadMask1 = 8'h80;
  localparam logic [7:0] LeadMask2 = 8'hE0;
  localparam logic [7:0] LeadPat2  = 8'hC0;
  localparam logic [7:0] LeadMask3 = 8'hF0;
  localparam logic [7:0] LeadPat3  = 8'hE0;
  localparam logic [7:0] LeadMask4 = 8'hF8;
  localparam logic [7:0] LeadPat4  = 8'hF0;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContPat   = 8'h80;

  typedef enum logic {
    REQ_DATA  = 1'b0,
    REQ_FLUSH = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [31:0] char_bytes;
    logic [2:0]  byte_count;
    logic        is_flush;
    logic        last;
  } res_t;

  // Character length from a lead byte; zero for a byte that cannot lead.
  function automatic logic [2:0] lead_len(logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    if ((c & LeadMask1) == 8'h00) begin
      len = 3'd1;
    end else if ((c & LeadMask2) == LeadPat2) begin
      len = 3'd2;
    end else if ((c & LeadMask3) == LeadPat3) begin
      len = 3'd3;
    end else if ((c & LeadMask4) == LeadPat4) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== src/utf8r_scan.sv =====
// ----------------------------------------------------------------------------
// utf8r_scan
// Single-pass framing of held bytes plus one new byte into characters, or a flush of the held bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8r_scan
  import utf8r_pkg::*;
(
  input  logic       req_type_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] held_i [HeldDepth],
  input  logic [1:0] held_cnt_i,
  output res_t       res_o [MaxRes],
  output logic [1:0] nres_o,
  output logic [7:0] held_o [HeldDepth],
  output logic [1:0] held_cnt_o
);

  always_comb begin : scan_comb
    logic [7:0] bb [4];
    logic [2:0] n;
    logic [2:0] i;
    logic [2:0] len;
    logic [2:0] nres;
    logic [2:0] rem;
    logic       stop;
    logic       ok;

    for (int k = 0; k < MaxRes; k++) begin
      res_o[k] = '0;
    end
    for (int k = 0; k < 4; k++) begin
      bb[k] = '0;
    end
    n    = '0;
    i    = '0;
    len  = '0;
    nres = '0;
    rem  = '0;
    stop = 1'b0;
    ok   = 1'b0;
    for (int k = 0; k < HeldDepth; k++) begin
      held_o[k] = held_i[k];
    end
    held_cnt_o = held_cnt_i;

    if (req_type_i == REQ_FLUSH) begin
      if (held_cnt_i != 2'd0) begin
        for (int k = 0; k < HeldDepth; k++) begin
          if (2'(k) < held_cnt_i) begin
            res_o[0].char_bytes[8*k +: 8] = held_i[k];
          end
        end
        res_o[0].byte_count = {1'b0, held_cnt_i};
        res_o[0].is_flush   = 1'b1;
        res_o[0].last       = 1'b1;
        nres                = 3'd1;
      end
      held_cnt_o = 2'd0;
    end else begin
      for (int k = 0; k < HeldDepth; k++) begin
        bb[k] = held_i[k];
      end
      bb[held_cnt_i] = data_byte_i;
      n = {1'b0, held_cnt_i} + 3'd1;

      for (int s = 0; s < 4; s++) begin
        if (!stop && (i < n)) begin
          len = lead_len(bb[i[1:0]]);
          if (len == 3'd0) begin
            i = i + 3'd1;
          end else if ((i + len) > n) begin
            stop = 1'b1;
          end else begin
            ok = 1'b1;
            for (int j = 1; j < 4; j++) begin
              if ((3'(j) < len) && ((bb[2'(i + 3'(j))] & ContMask) != ContPat)) begin
                ok = 1'b0;
              end
            end
            if (ok) begin
              if (nres < 3'(MaxRes)) begin
                for (int k = 0; k < 4; k++) begin
                  if (3'(k) < len) begin
                    res_o[nres[1:0]].char_bytes[8*k +: 8] = bb[2'(i + 3'(k))];
                  end
                end
                res_o[nres[1:0]].byte_count = len;
                nres = nres + 3'd1;
              end
              i = i + len;
            end else begin
              i = i + 3'd1;
            end
          end
        end
      end

      if (nres != 3'd0) begin
        res_o[2'(nres - 3'd1)].last = 1'b1;
      end

      rem = n - i;
      held_cnt_o = (rem > 3'd3) ? 2'd3 : rem[1:0];
      for (int k = 0; k < HeldDepth; k++) begin
        held_o[k] = bb[2'(i + 3'(k))];
      end
    end

    nres_o = nres[1:0];
  end

endmodule

`default_nettype wire

// ===== src/utf8_char_reassembler_core.sv =====
// ----------------------------------------------------------------------------
// utf8_char_reassembler_core
// Frames a byte stream into complete UTF-8 characters of one to four bytes.
//
// Input channel: in_valid_i / in_stall_o carry one request per transfer,
// either a data byte or a flush of the held leftover bytes.
// Output channel: out_valid_o / out_stall_i carry one character (or one
// block of flushed leftovers) per transfer; out_last_o marks the final
// result caused by a request. A request may cause zero to three results.
// Each request is held in the input register, then framed by the scan logic
// into the registered result queue, which presents its first result.
// Throughput: one request per cycle while each request yields at most one
// result and the receiver does not stall; a request with several results
// holds the queue until they drain, and the input register absorbs one
// further request meanwhile. The rate is set by the single output port
// draining the three-entry result queue.
// Reset clears the input register, the result queue and the held count.
// When the receiver stalls, the queue holds its head and the input side
// stalls once the input register is occupied and cannot be drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_char_reassembler_core
  import utf8r_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_req_type_i,
  input  logic [7:0]  in_data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_char_bytes_o,
  output logic [2:0]  out_byte_count_o,
  output logic        out_is_flush_o,
  output logic        out_last_o
);

  logic       in_v_q, in_v_d;
  logic       in_req_q;
  logic [7:0] in_byte_q;

  logic [7:0] held_q [HeldDepth];
  logic [7:0] held_d [HeldDepth];
  logic [1:0] held_cnt_q, held_cnt_d;

  res_t       res_q [MaxRes];
  res_t       scan_res [MaxRes];
  logic [1:0] scan_nres;
  logic [1:0] res_cnt_q;

  logic in_xfer, out_xfer, res_free, consume;

  utf8r_scan u_scan (
    .req_type_i  (in_req_q),
    .data_byte_i (in_byte_q),
    .held_i      (held_q),
    .held_cnt_i  (held_cnt_q),
    .res_o       (scan_res),
    .nres_o      (scan_nres),
    .held_o      (held_d),
    .held_cnt_o  (held_cnt_d)
  );

  assign out_xfer   = out_valid_o && !out_stall_i;
  assign res_free   = (res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && !out_stall_i);
  assign consume    = in_v_q && res_free;
  assign in_stall_o = in_v_q && !res_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_v_d     = in_xfer ? 1'b1 : (consume ? 1'b0 : in_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_req_q  <= in_req_type_i;
      in_byte_q <= in_data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
    end else if (consume) begin
      held_cnt_q <= held_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      for (int k = 0; k < HeldDepth; k++) begin
        held_q[k] <= held_d[k];
      end
    end
  end

  // Result queue: head at entry 0, refilled only when empty or when its last entry is draining.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= 2'd0;
    end else if (consume) begin
      res_cnt_q <= scan_nres;
    end else if (out_xfer) begin
      res_cnt_q <= res_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      for (int k = 0; k < MaxRes; k++) begin
        res_q[k] <= scan_res[k];
      end
    end else if (out_xfer) begin
      for (int k = 0; k < MaxRes - 1; k++) begin
        res_q[k] <= res_q[k+1];
      end
    end
  end

  assign out_valid_o      = (res_cnt_q != 2'd0);
  assign out_char_bytes_o = res_q[0].char_bytes;
  assign out_byte_count_o = res_q[0].byte_count;
  assign out_is_flush_o   = res_q[0].is_flush;
  assign out_last_o       = res_q[0].last;

  a_held_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_cnt_q != 2'd0) |-> (lead_len(held_q[0]) > {1'b0, held_cnt_q}))
    else $error("held bytes do not start with an incomplete lead");

  a_last_at_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_cnt_q >= 2'd2) |-> !res_q[0].last)
    else $error("last flag ahead of queue tail");

  a_tail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_cnt_q == 2'd1) |-> res_q[0].last)
    else $error("queue tail without last flag");

  a_flush_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_is_flush_o) |-> (res_cnt_q == 2'd1))
    else $error("flush result not alone");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_byte_count_o != 3'd0) && (out_byte_count_o <= 3'd4)))
    else $error("byte count out of range");

endmodule

`default_nettype wire
